// ===== hw/rtl/jsu_pkg.sv =====
package jsu_pkg;

  localparam logic [1:0] MODE_WAIT = 2'd0;
  localparam logic [1:0] MODE_BODY = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  localparam logic [1:0] ST_RUN    = 2'd0;
  localparam logic [1:0] ST_CLOSED = 2'd1;
  localparam logic [1:0] ST_UNTERM = 2'd2;
  localparam logic [1:0] ST_NOSTR  = 2'd3;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_U = 8'h75;
  localparam logic [7:0] REPL_RESET = 8'h3f;

  // One classified input byte: literal held digits first, then an optional tail result.
  typedef struct packed {
    logic [1:0]       held_cnt;
    logic [2:0][7:0]  held;
    logic             has_tail;
    logic [7:0]       tail_byte;
    logic             tail_valid;
    logic [1:0]       tail_status;
  } cmd_t;

  // {is_hex, value}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h62:   r = 8'd8;
      8'h66:   r = 8'd12;
      8'h6e:   r = 8'd10;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/jsu_front.sv =====
module jsu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [7:0]         data_byte_i,
  input  logic               cfg_wr_en_i,
  input  logic [7:0]         cfg_wr_data_i,
  output logic               push_o,
  output jsu_pkg::cmd_t      cmd_o
);

  logic [1:0]      mode_q, mode_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0][7:0] held_q;
  logic [7:0]      repl_q;
  logic            store;
  logic [4:0]      nib_b, nib0, nib1, nib2;
  jsu_pkg::cmd_t   cmd;

  assign nib_b = jsu_pkg::nibble_of(data_byte_i);
  assign nib0  = jsu_pkg::nibble_of(held_q[0]);
  assign nib1  = jsu_pkg::nibble_of(held_q[1]);
  assign nib2  = jsu_pkg::nibble_of(held_q[2]);

  always_comb begin
    mode_d = mode_q;
    cnt_d  = cnt_q;
    store  = 1'b0;
    cmd    = '0;
    cmd.held = held_q;
    unique case (mode_q)
      jsu_pkg::MODE_WAIT: begin
        if (data_byte_i == jsu_pkg::CH_QUOTE) begin
          mode_d = jsu_pkg::MODE_BODY;
          cnt_d  = 2'd0;
        end else begin
          cmd.has_tail    = 1'b1;
          cmd.tail_status = jsu_pkg::ST_NOSTR;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (data_byte_i == 8'd0) begin
          mode_d          = jsu_pkg::MODE_WAIT;
          cmd.has_tail    = 1'b1;
          cmd.tail_status = jsu_pkg::ST_UNTERM;
        end else if (data_byte_i == jsu_pkg::CH_U) begin
          mode_d = jsu_pkg::MODE_HEX;
          cnt_d  = 2'd0;
        end else begin
          mode_d         = jsu_pkg::MODE_BODY;
          cmd.has_tail   = 1'b1;
          cmd.tail_valid = 1'b1;
          cmd.tail_byte  = jsu_pkg::escape_map(data_byte_i);
        end
      end
      default: begin
        // body byte, or a digit slot of \u
        if (mode_q == jsu_pkg::MODE_HEX && nib_b[4]) begin
          if (cnt_q != 2'd3) begin
            store = 1'b1;
            cnt_d = cnt_q + 2'd1;
          end else begin
            mode_d         = jsu_pkg::MODE_BODY;
            cnt_d          = 2'd0;
            cmd.has_tail   = 1'b1;
            cmd.tail_valid = 1'b1;
            if (nib0[3:0] == 4'd0 && nib1[3:0] == 4'd0 && !nib2[3]) begin
              cmd.tail_byte = {1'b0, nib2[2:0], nib_b[3:0]};
            end else begin
              cmd.tail_byte = repl_q;
            end
          end
        end else begin
          if (mode_q == jsu_pkg::MODE_HEX) begin
            cmd.held_cnt = cnt_q;
            cnt_d        = 2'd0;
          end
          priority if (data_byte_i == 8'd0) begin
            mode_d          = jsu_pkg::MODE_WAIT;
            cmd.has_tail    = 1'b1;
            cmd.tail_status = jsu_pkg::ST_UNTERM;
          end else if (data_byte_i == jsu_pkg::CH_QUOTE) begin
            mode_d          = jsu_pkg::MODE_WAIT;
            cmd.has_tail    = 1'b1;
            cmd.tail_status = jsu_pkg::ST_CLOSED;
          end else if (data_byte_i == jsu_pkg::CH_BSLASH) begin
            mode_d = jsu_pkg::MODE_ESC;
          end else begin
            mode_d         = jsu_pkg::MODE_BODY;
            cmd.has_tail   = 1'b1;
            cmd.tail_valid = 1'b1;
            cmd.tail_byte  = data_byte_i;
          end
        end
      end
    endcase
  end

  assign cmd_o  = cmd;
  assign push_o = accept_i && (cmd.has_tail || cmd.held_cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= jsu_pkg::MODE_WAIT;
      cnt_q  <= 2'd0;
      repl_q <= jsu_pkg::REPL_RESET;
    end else begin
      if (accept_i) begin
        mode_q <= mode_d;
        cnt_q  <= cnt_d;
      end
      if (cfg_wr_en_i) begin
        repl_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && store) begin
      held_q[cnt_q] <= data_byte_i;
    end
  end

endmodule

// ===== hw/rtl/jsu_fifo.sv =====
module jsu_fifo #(
  parameter int Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jsu_pkg::cmd_t  push_data_i,
  input  logic           pop_i,
  output jsu_pkg::cmd_t  head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  jsu_pkg::cmd_t       slot_q [Depth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign head_o  = slot_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/jsu_back.sv =====
module jsu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  jsu_pkg::cmd_t  head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           res_valid_o,
  input  logic           res_stall_i,
  output logic [7:0]     out_byte_o,
  output logic           out_valid_o,
  output logic [1:0]     status_o,
  output logic           last_o
);

  logic [1:0] idx_q;
  logic       ov_q;
  logic [7:0] byte_q, byte_d;
  logic       val_q, val_d;
  logic [1:0] st_q, st_d;
  logic       last_q, last_d;
  logic [2:0] total;
  logic       load;

  assign total = {1'b0, head_i.held_cnt} + {2'b00, head_i.has_tail};
  assign load  = !empty_i && (!ov_q || !res_stall_i);

  always_comb begin
    if (idx_q < head_i.held_cnt) begin
      val_d = 1'b1;
      st_d  = jsu_pkg::ST_RUN;
      unique case (idx_q)
        2'd1:    byte_d = head_i.held[1];
        2'd2:    byte_d = head_i.held[2];
        default: byte_d = head_i.held[0];
      endcase
    end else begin
      byte_d = head_i.tail_byte;
      val_d  = head_i.tail_valid;
      st_d   = head_i.tail_status;
    end
    last_d = ({1'b0, idx_q} == total - 3'd1);
  end

  assign pop_o = load && last_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
      ov_q  <= 1'b0;
    end else begin
      if (load) begin
        ov_q  <= 1'b1;
        idx_q <= last_d ? 2'd0 : idx_q + 2'd1;
      end else if (!res_stall_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_d;
      val_q  <= val_d;
      st_q   <= st_d;
      last_q <= last_d;
    end
  end

  assign res_valid_o = ov_q;
  assign out_byte_o  = byte_q;
  assign out_valid_o = val_q;
  assign status_o    = st_q;
  assign last_o      = last_q;

endmodule

// ===== hw/rtl/json_string_unescaper.sv =====
// Channel | Direction | Handshake                  | Beat carries
// --------+-----------+----------------------------+-------------------------------------
// in      | input     | in_valid_i / in_stall_o    | data_byte_i
// res     | output    | res_valid_o / res_stall_i  | out_byte_o out_valid_o status_o last_o
// cfg     | input     | cfg_wr_en_i                | cfg_wr_data_i (replacement byte)
//
// One input beat per cycle is taken while the command queue has room; each beat
// yields at most one queue entry. The back end sends one result beat per cycle while
// res_stall_i is low, so a failed \u escape (up to four result beats) keeps it busy
// and the queue absorbs that burst. An entry reaches the result port through the
// queue and then the output register.
// Reset clears the decode mode, digit count, queue and result valid flag; the held
// digits and output data carry no reset. A stall on the result side fills the queue,
// after which in_stall_o rises; the input side never blocks the output.
module json_string_unescaper #(
  parameter int FifoDepth = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  output logic       res_valid_o,
  input  logic       res_stall_i,
  output logic [7:0] out_byte_o,
  output logic       out_valid_o,
  output logic [1:0] status_o,
  output logic       last_o,
  input  logic       cfg_wr_en_i,
  input  logic [7:0] cfg_wr_data_i
);

  jsu_pkg::cmd_t push_cmd, head_cmd;
  logic          push, pop, empty, full, accept;

  // Hold the input whenever the queue cannot take another entry.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Classify bytes and track the escape state.
  jsu_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .push_o        (push),
    .cmd_o         (push_cmd)
  );

  // Decouple the two halves.
  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .head_o      (head_cmd),
    .empty_o     (empty),
    .full_o      (full)
  );

  // Expand each entry into result beats.
  jsu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_cmd),
    .empty_i     (empty),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .out_byte_o  (out_byte_o),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
